// ===== hdl/pwd_pkg.sv =====
// Package for the pixel distance-from-white block.
// Shared widths and constants; no dependencies.
package pwd_pkg;

	localparam int unsigned CHAN_W   = 8;   // one colour channel
	localparam int unsigned SQ_W     = 16;  // square of one channel difference
	localparam int unsigned NUM_CHAN = 3;   // lanes, one per channel
	localparam int unsigned SUM_W    = 18;  // 3 * 255^2 = 195075 fits
	localparam int unsigned CFG_W    = 2;   // channel count register
	localparam int unsigned DIST_W   = 17;  // result width

	localparam logic [CHAN_W-1:0] WHITE_LEVEL = 8'd255;
	localparam logic [CFG_W-1:0]  CHANS_RESET = 2'd3;

endpackage

// ===== hdl/pwd_lane.sv =====
// One channel lane: difference from white, squared, gated by lane enable.
// Depends on pwd_pkg.
module pwd_lane
	import pwd_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [CHAN_W-1:0] chan,
	output logic [SQ_W-1:0]   sq_s1
);

	logic [CHAN_W-1:0] diff;

	assign diff = WHITE_LEVEL - chan;

	// widen before the multiply so the full 16-bit square is kept
	always_ff @(posedge clk) begin
		sq_s1 <= en ? (SQ_W'(diff) * SQ_W'(diff)) : '0;
	end

endmodule

// ===== hdl/pwd_sqrt.sv =====
// Pipelined integer square root of (sum << 2*FRAC_BITS), one root bit per stage.
// Depends on pwd_pkg.
module pwd_sqrt
	import pwd_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 8
)(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic [SUM_W-1:0]           in_sum,
	output logic                       out_vld,
	output logic [SUM_W/2+FRAC_BITS-1:0] out_root
);

	localparam int unsigned RAD_W  = SUM_W + 2 * FRAC_BITS;
	localparam int unsigned ROOT_W = RAD_W / 2;
	localparam int unsigned REM_W  = ROOT_W + 3;

	// stage k registers live at index k+1
	logic [RAD_W-1:0]  rad_s  [1:ROOT_W];
	logic [REM_W-1:0]  rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];
	logic [ROOT_W:1]   vld_s;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [RAD_W-1:0]  cur_rad;
		logic [REM_W-1:0]  cur_rem;
		logic [ROOT_W-1:0] cur_root;
		logic              cur_vld;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign cur_rad  = RAD_W'(in_sum) << (2 * FRAC_BITS);
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_vld  = in_vld;
		end else begin : g_next
			assign cur_rad  = rad_s[k];
			assign cur_rem  = rem_s[k];
			assign cur_root = root_s[k];
			assign cur_vld  = vld_s[k];
		end

		// bring down the next radicand bit pair, try root*4+1
		assign rem_sh = {cur_rem[REM_W-3:0], cur_rad[RAD_W-1 -: 2]};
		assign trial  = REM_W'({cur_root, 2'b01});
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k+1]  <= cur_rad << 2;
			rem_s[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
			root_s[k+1] <= {cur_root[ROOT_W-2:0], ge};
		end
	end

	assign out_vld  = vld_s[ROOT_W];
	assign out_root = root_s[ROOT_W];

endmodule

// ===== hdl/pixel_white_distance.sv =====
// Top level: Euclidean distance of an RGB pixel from pure white.
// Depends on pwd_pkg, pwd_lane and pwd_sqrt.
//
// Usage:
//  - Input: drive chan_zero/chan_one/chan_two and pulse start. A beat is
//    taken at every edge with start high and busy low. busy is always low:
//    the block takes one pixel per clock, every clock.
//  - Result: done is high for exactly one cycle with distance valid in
//    that cycle. The receiver cannot stall; every result must be sampled.
//  - distance = floor(sqrt(sum of (255 - chan)^2) * 2^FRAC_BITS), kept to
//    17 bits (wraps if FRAC_BITS makes the root wider).
//  - Config: cfg_valid/cfg_ready/cfg_data writes channels_in_use (0..3);
//    lane k enters the sum when k < channels_in_use. cfg_ready is always
//    high. Write only while no pixel is in flight.
//  - Pipeline from start to done: one lane square stage, one merge adder
//    stage, then 9 + FRAC_BITS square-root stages, one root bit per stage.
//    Throughput: one pixel per cycle.
//  - Reset (arst_n low, asynchronous): pipeline valids clear, nothing in
//    flight, channels_in_use returns to 3.
module pixel_white_distance
	import pwd_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 8
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CHAN_W-1:0] chan_zero,
	input  logic [CHAN_W-1:0] chan_one,
	input  logic [CHAN_W-1:0] chan_two,
	output logic              done,
	output logic [DIST_W-1:0] distance,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int unsigned ROOT_W = SUM_W / 2 + FRAC_BITS;

	logic [CFG_W-1:0]  chans_q;
	logic [CHAN_W-1:0] chan_in [NUM_CHAN];
	logic [SQ_W-1:0]   sq_s1   [NUM_CHAN];
	logic              vld_s1;
	logic              vld_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic              root_vld;
	logic [ROOT_W-1:0] root;

	// fully pipelined, never holds off a beat
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chans_q <= CHANS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			chans_q <= cfg_data;
		end
	end

	assign chan_in[0] = chan_zero;
	assign chan_in[1] = chan_one;
	assign chan_in[2] = chan_two;

	// lanes: one per colour channel, enabled by the channel count
	for (genvar i = 0; i < NUM_CHAN; i++) begin : g_lane
		pwd_lane u_lane (
			.clk   (clk),
			.en    (CFG_W'(i) < chans_q),
			.chan  (chan_in[i]),
			.sq_s1 (sq_s1[i])
		);
	end

	// merge: sum of the lane squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);
	end

	pwd_sqrt #(
		.FRAC_BITS (FRAC_BITS)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s2),
		.in_sum   (sum_s2),
		.out_vld  (root_vld),
		.out_root (root)
	);

	assign done     = root_vld;
	assign distance = DIST_W'(root);

endmodule
